FILE: sv/lpc_pkg.sv
// Package for the local peak clip block: widths, register indexes, job and config types,
// and the small helper functions shared by the front and back modules.
// No dependencies.
package lpc_pkg;

  localparam int unsigned VALUE_W     = 30;
  localparam int unsigned COL_W       = 6;
  localparam int unsigned ROW_W       = 16;
  localparam int unsigned RING_W      = 2;
  localparam int unsigned ADDR_W      = RING_W + COL_W;
  localparam int unsigned STORE_DEPTH = 192;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned FIFO_PTR_W  = 2;
  localparam int unsigned FIFO_CNT_W  = 3;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef struct packed {
    logic [COL_W-1:0] grid_width;
    logic [ROW_W-1:0] grid_height;
  } cfg_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COL_W-1:0]   col;
    logic [RING_W-1:0]  ring;
    logic               row_gt0;
    logic               row_gt1;
    logic               last_frame;
  } job_t;

  function automatic logic [COL_W-1:0] eff_width(input logic [COL_W-1:0] w);
    return (w == '0) ? COL_W'(1) : w;
  endfunction

  function automatic logic [ROW_W-1:0] eff_height(input logic [ROW_W-1:0] h);
    return (h == '0) ? ROW_W'(1) : h;
  endfunction

  // Row index modulo 3: base-4 digits sum to the same residue.
  function automatic logic [1:0] mod3(input logic [ROW_W-1:0] x);
    logic [4:0] s1;
    logic [2:0] s2;
    logic [2:0] s3;
    s1 = '0;
    for (int i = 0; i < 8; i++) begin
      s1 = s1 + 5'(x[2*i +: 2]);
    end
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
    s3 = 3'(s2[1:0]) + 3'(s2[2]);
    return (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
  endfunction

  function automatic logic [RING_W-1:0] ring_prev(input logic [RING_W-1:0] r);
    logic [RING_W-1:0] p;
    unique case (r)
      2'd0:    p = 2'd2;
      2'd1:    p = 2'd0;
      default: p = 2'd1;
    endcase
    return p;
  endfunction

endpackage

FILE: sv/lpc_front.sv
// Front end: accepts grid cells, tracks column and row, classifies each cell into a job.
// Depends on lpc_pkg.
module lpc_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lpc_pkg::cfg_t              cfg_i,
  input  logic                       cell_valid_i,
  input  logic [lpc_pkg::VALUE_W-1:0] cell_value_i,
  input  logic                       fifo_full_i,
  output logic                       ready_o,
  output logic                       push_o,
  output lpc_pkg::job_t              job_o
);

  logic [lpc_pkg::COL_W-1:0] col_q, col_d;
  logic [lpc_pkg::ROW_W-1:0] row_q, row_d;
  logic [lpc_pkg::COL_W-1:0] w, wl, c;
  logic [lpc_pkg::ROW_W-1:0] h, hl, r;
  logic                      last_col, last_row;

  assign w  = lpc_pkg::eff_width(cfg_i.grid_width);
  assign h  = lpc_pkg::eff_height(cfg_i.grid_height);
  assign wl = w - lpc_pkg::COL_W'(1);
  assign hl = h - lpc_pkg::ROW_W'(1);
  assign c  = (col_q < w) ? col_q : wl;
  assign r  = (row_q < h) ? row_q : hl;

  assign last_col = (c == wl);
  assign last_row = (r == hl);

  assign ready_o = !fifo_full_i;
  assign push_o  = cell_valid_i && !fifo_full_i;

  assign job_o.value      = cell_value_i;
  assign job_o.col        = c;
  assign job_o.ring       = lpc_pkg::mod3(r);
  assign job_o.row_gt0    = (r != '0);
  assign job_o.row_gt1    = (r > lpc_pkg::ROW_W'(1));
  assign job_o.last_frame = last_col && last_row;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (push_o) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : r + lpc_pkg::ROW_W'(1);
      end else begin
        col_d = c + lpc_pkg::COL_W'(1);
        row_d = r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

FILE: sv/lpc_fifo.sv
// Job queue between the front and back ends; four entries.
// Depends on lpc_pkg.
module lpc_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lpc_pkg::job_t push_data_i,
  input  logic          pop_i,
  output lpc_pkg::job_t pop_data_o,
  output logic          full_o,
  output logic          empty_o
);

  lpc_pkg::job_t                    entry_q [lpc_pkg::FIFO_DEPTH];
  logic [lpc_pkg::FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [lpc_pkg::FIFO_CNT_W-1:0]   count_q;

  assign full_o     = (count_q == lpc_pkg::FIFO_CNT_W'(lpc_pkg::FIFO_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + lpc_pkg::FIFO_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + lpc_pkg::FIFO_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + lpc_pkg::FIFO_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - lpc_pkg::FIFO_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: sv/lpc_back.sv
// Back end: writes each job's cell into the three-row store, reads the neighbors,
// clips strict peaks and drives the output register. Depends on lpc_pkg.
module lpc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lpc_pkg::cfg_t               cfg_i,
  input  logic                        fifo_empty_i,
  input  lpc_pkg::job_t               job_i,
  output logic                        pop_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [lpc_pkg::VALUE_W-1:0] out_value_o,
  output logic                        out_last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ_A,
    ST_READ_B,
    ST_CALC
  } state_e;

  state_e state_q, state_d;
  logic   flush_q, flush_d;
  logic   pend_flush_q, pend_flush_d;
  logic   out_valid_q, out_valid_d;

  logic [lpc_pkg::VALUE_W-1:0] store_q [lpc_pkg::STORE_DEPTH];
  logic [lpc_pkg::VALUE_W-1:0] rd0_q, rd1_q;
  logic [lpc_pkg::ADDR_W-1:0]  rd_addr0, rd_addr1, wr_addr;

  logic [lpc_pkg::RING_W-1:0]  ring_q, crow_q, urow_q;
  logic [lpc_pkg::COL_W-1:0]   col_q;
  logic                        gt0_q, up_en_q, down_en_q;
  logic [lpc_pkg::VALUE_W-1:0] down_q, center_q, up_q;
  logic [lpc_pkg::VALUE_W-1:0] out_value_q;
  logic                        out_last_q;

  logic [lpc_pkg::COL_W-1:0]   w, wl;
  logic                        left_en, right_en, out_free;
  logic                        start_clip, flush_from_job, flush_from_reg, step_flush, load_out;
  logic                        any_nb, ge_nb;
  logic [lpc_pkg::VALUE_W-1:0] max_nb, clip_val;

  assign w        = lpc_pkg::eff_width(cfg_i.grid_width);
  assign wl       = w - lpc_pkg::COL_W'(1);
  assign left_en  = (col_q != '0);
  assign right_en = (col_q != wl);
  assign out_free = !out_valid_q || out_ready_i;

  // Left and right neighbors arrive in rd0_q and rd1_q during the compute cycle.
  always_comb begin
    any_nb = up_en_q || down_en_q || left_en || right_en;
    ge_nb  = (up_en_q && (up_q >= center_q)) || (down_en_q && (down_q >= center_q)) ||
             (left_en && (rd0_q >= center_q)) || (right_en && (rd1_q >= center_q));
    max_nb = '0;
    if (up_en_q && (up_q > max_nb)) begin
      max_nb = up_q;
    end
    if (down_en_q && (down_q > max_nb)) begin
      max_nb = down_q;
    end
    if (left_en && (rd0_q > max_nb)) begin
      max_nb = rd0_q;
    end
    if (right_en && (rd1_q > max_nb)) begin
      max_nb = rd1_q;
    end
    clip_val = (ge_nb || !any_nb) ? center_q : max_nb;
  end

  always_comb begin
    state_d        = state_q;
    flush_d        = flush_q;
    pend_flush_d   = pend_flush_q;
    out_valid_d    = out_ready_i ? 1'b0 : out_valid_q;
    pop_o          = 1'b0;
    start_clip     = 1'b0;
    flush_from_job = 1'b0;
    flush_from_reg = 1'b0;
    step_flush     = 1'b0;
    load_out       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!fifo_empty_i) begin
          pop_o        = 1'b1;
          pend_flush_d = job_i.last_frame;
          if (job_i.row_gt0) begin
            start_clip = 1'b1;
            flush_d    = 1'b0;
            state_d    = ST_READ_A;
          end else if (job_i.last_frame) begin
            flush_from_job = 1'b1;
            flush_d        = 1'b1;
            state_d        = ST_READ_A;
          end
        end
      end
      ST_READ_A: begin
        state_d = ST_READ_B;
      end
      ST_READ_B: begin
        state_d = ST_CALC;
      end
      ST_CALC: begin
        if (out_free) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          if (!flush_q && pend_flush_q) begin
            flush_from_reg = 1'b1;
            flush_d        = 1'b1;
            state_d        = ST_READ_A;
          end else if (flush_q && right_en) begin
            step_flush = 1'b1;
            state_d    = ST_READ_A;
          end else begin
            flush_d = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      flush_q      <= 1'b0;
      pend_flush_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      flush_q      <= flush_d;
      pend_flush_q <= pend_flush_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ring_q <= job_i.ring;
      gt0_q  <= job_i.row_gt0;
    end
    if (start_clip) begin
      col_q     <= job_i.col;
      crow_q    <= lpc_pkg::ring_prev(job_i.ring);
      urow_q    <= lpc_pkg::ring_prev(lpc_pkg::ring_prev(job_i.ring));
      up_en_q   <= job_i.row_gt1;
      down_en_q <= 1'b1;
      down_q    <= job_i.value;
    end
    if (flush_from_job) begin
      col_q     <= '0;
      crow_q    <= job_i.ring;
      urow_q    <= lpc_pkg::ring_prev(job_i.ring);
      up_en_q   <= job_i.row_gt0;
      down_en_q <= 1'b0;
    end
    if (flush_from_reg) begin
      col_q     <= '0;
      crow_q    <= ring_q;
      urow_q    <= lpc_pkg::ring_prev(ring_q);
      up_en_q   <= gt0_q;
      down_en_q <= 1'b0;
    end
    if (step_flush) begin
      col_q <= col_q + lpc_pkg::COL_W'(1);
    end
    if (state_q == ST_READ_B) begin
      center_q <= rd0_q;
      up_q     <= rd1_q;
    end
    if (load_out) begin
      out_value_q <= clip_val;
      out_last_q  <= flush_q && !right_en;
    end
  end

  assign wr_addr  = {job_i.ring, job_i.col};
  assign rd_addr0 = (state_q == ST_READ_A) ? {crow_q, col_q}
                                           : {crow_q, col_q - lpc_pkg::COL_W'(1)};
  assign rd_addr1 = (state_q == ST_READ_A) ? {urow_q, col_q}
                                           : {crow_q, col_q + lpc_pkg::COL_W'(1)};

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      store_q[wr_addr] <= job_i.value;
    end
    if ((state_q == ST_READ_A) || (state_q == ST_READ_B)) begin
      rd0_q <= store_q[rd_addr0];
      rd1_q <= store_q[rd_addr1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: sv/local_peak_clip_4n.sv
// Top level of the strict local maximum clip over a 4-neighbor grid.
// Holds the APB register file; instantiates lpc_front, lpc_fifo and lpc_back (lpc_pkg).
//
// Cells of a grid_height x grid_width grid enter on the s_axis channel in raster order,
// value in s_axis_tdata[29:0]. Clipped cells leave on m_axis in raster order, value in
// m_axis_tdata[29:0], m_axis_tlast high on the last cell of the frame. A cell strictly
// above all its in-grid up/down/left/right neighbors is replaced by their maximum.
// Output lags input by one row: the cell at (r, c) with r > 0 releases cell (r-1, c), and
// the last cell of the frame also releases the whole last row.
// The front accepts one beat per cycle into a four-entry job queue while the queue is not
// full. The back sequencer pops a first-row beat and only stores it; for each result it
// steps through pop, two store reads and one compute step, and it pops the next job only
// after the compute step has loaded the output register. At frame end the last row is
// flushed one cell at a time through the store reads and the compute step.
// A stalled m_axis holds the output register and the back end; the queue then fills and
// s_axis_tready drops. Reset clears counters, queue and output; grid_width resets to 63,
// grid_height to 1. Row store content is undefined until written.
// Write registers over APB only while no results are pending.
module local_peak_clip_4n (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration: grid_width at 0x0, grid_height at 0x4
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // [29:0] cell_value, [31:30] zero
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  // [29:0] out_value, [31:30] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  lpc_pkg::cfg_t cfg_q;
  logic          cfg_wr;
  logic          fifo_push, fifo_pop, fifo_full, fifo_empty;
  lpc_pkg::job_t push_job, pop_job;
  logic [lpc_pkg::VALUE_W-1:0] out_value;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_width  <= lpc_pkg::COL_W'(63);
      cfg_q.grid_height <= lpc_pkg::ROW_W'(1);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        lpc_pkg::REG_GRID_WIDTH:  cfg_q.grid_width  <= pwdata[lpc_pkg::COL_W-1:0];
        lpc_pkg::REG_GRID_HEIGHT: cfg_q.grid_height <= pwdata[lpc_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      lpc_pkg::REG_GRID_WIDTH:  prdata = 32'(cfg_q.grid_width);
      lpc_pkg::REG_GRID_HEIGHT: prdata = 32'(cfg_q.grid_height);
      default:                  prdata = '0;
    endcase
  end

  lpc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cell_valid_i (s_axis_tvalid),
    .cell_value_i (s_axis_tdata[lpc_pkg::VALUE_W-1:0]),
    .fifo_full_i  (fifo_full),
    .ready_o      (s_axis_tready),
    .push_o       (fifo_push),
    .job_o        (push_job)
  );

  lpc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .push_data_i (push_job),
    .pop_i       (fifo_pop),
    .pop_data_o  (pop_job),
    .full_o      (fifo_full),
    .empty_o     (fifo_empty)
  );

  lpc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .fifo_empty_i (fifo_empty),
    .job_i        (pop_job),
    .pop_o        (fifo_pop),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_value_o  (out_value),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_value};

endmodule
